/* hdl/rmdr_pkg.sv */
// ---------------------------------------------------------------------------
// Rational multiply/divide package
// Request and result types and codes shared by the rational reduce block.
// ---------------------------------------------------------------------------
package rmdr_pkg;

	localparam logic [0:0] CMD_MUL = 1'b0;
	localparam logic [0:0] CMD_DIV = 1'b1;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_ZDEN  = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [31:0] a_num;
		logic [30:0] a_den;
		logic [31:0] b_num;
		logic [30:0] b_den;
	} req_t;

	typedef struct packed {
		logic [31:0] res_num;
		logic [30:0] res_den;
		logic [1:0]  error;
	} res_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE, OP_LOAD, OP_MUL, OP_DIV, OP_GCD_SWAP, OP_REDUCE_N, OP_REDUCE_D, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t  op;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic den_zero;
		logic num_zero;
		logic rem_zero;
	} sts_t;

endpackage

/* hdl/rational_mul_div_reduce.sv */
// Each Euclid step runs one division on the 64-bit radix-2 divider; a zero
// numerator or denominator skips the Euclid loop and the reduction.
// Throughput: one request at a time; start is taken only while busy is low,
// and busy falls the cycle after the valid strobe.
// The result is shown for one cycle with valid; the receiver cannot stall.
// Reset (arst_n low) returns the controller to idle; no request survives.
// ---------------------------------------------------------------------------
// Rational multiply/divide with reduction
// Forms the exact cross products and reduces them by their GCD.
// ---------------------------------------------------------------------------
module rational_mul_div_reduce #(
	parameter int WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rmdr_pkg::req_t req,
	output logic           busy,
	output logic           valid,
	output rmdr_pkg::res_t res
);

	rmdr_pkg::cmd_t ctl;
	rmdr_pkg::sts_t sts;
	logic           busy_i;

	rmdr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start && !busy_i),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy_i),
		.valid (valid)
	);

	rmdr_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ctl   (ctl),
		.sts   (sts),
		.res   (res)
	);

	assign busy = busy_i;

endmodule

/* hdl/rmdr_div.sv */
// ---------------------------------------------------------------------------
// Radix-2 restoring divider
// Divides two 64-bit unsigned values, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rmdr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [63:0] rem
);

	logic [63:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	// Shift in the next dividend bit and try a subtract.
	assign shifted = {r_q, q_q[63]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= shifted[63:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q;

endmodule

/* hdl/rmdr_datapath.sv */
// ---------------------------------------------------------------------------
// Rational reduce datapath
// Holds the cross products, the Euclid operands and the shared divider.
// ---------------------------------------------------------------------------
module rmdr_datapath #(
	parameter int WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rmdr_pkg::req_t req,
	input  rmdr_pkg::cmd_t ctl,
	output rmdr_pkg::sts_t sts,
	output rmdr_pkg::res_t res
);

	localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

	logic        cmd_q;
	logic        neg_q;
	logic [31:0] an_q, bn_q, ad_q, bd_q;
	logic [63:0] n_q, d_q, x_q, y_q;
	logic [63:0] div_a, div_b, quot, rem;
	logic [31:0] an_mag, bn_mag;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic        div_done;
	logic        out_range;

	// Magnitudes of the signed numerators.
	assign an_mag = req.a_num[31] ? (~req.a_num + 32'd1) : req.a_num;
	assign bn_mag = req.b_num[31] ? (~req.b_num + 32'd1) : req.b_num;

	// One 32x32 multiplier shared by the two cross products.
	always_comb begin
		if (ctl.op == rmdr_pkg::OP_MUL) begin
			mul_a = an_q;
			mul_b = (cmd_q == rmdr_pkg::CMD_DIV) ? bd_q : bn_q;
		end else begin
			mul_a = ad_q;
			mul_b = (cmd_q == rmdr_pkg::CMD_DIV) ? bn_q : bd_q;
		end
	end
	assign prod = mul_a * mul_b;

	// Divider operands follow the step in progress.
	always_comb begin
		case (ctl.op)
			rmdr_pkg::OP_REDUCE_N: begin
				div_a = n_q;
				div_b = x_q;
			end
			rmdr_pkg::OP_REDUCE_D: begin
				div_a = d_q;
				div_b = x_q;
			end
			default: begin
				div_a = x_q;
				div_b = y_q;
			end
		endcase
	end

	rmdr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.div_start),
		.dividend(div_a),
		.divisor (div_b),
		.done    (div_done),
		.quot    (quot),
		.rem     (rem)
	);

	assign out_range = (d_q > LIM) || (n_q > (neg_q ? LIM + 64'd1 : LIM));

	// Operand and result registers.
	always_ff @(posedge clk) begin
		case (ctl.op)
			rmdr_pkg::OP_LOAD: begin
				cmd_q <= req.cmd;
				neg_q <= req.a_num[31] ^ req.b_num[31];
				an_q  <= an_mag;
				bn_q  <= bn_mag;
				ad_q  <= {1'b0, req.a_den};
				bd_q  <= {1'b0, req.b_den};
			end
			rmdr_pkg::OP_MUL: begin
				n_q <= prod;
				x_q <= prod;
			end
			rmdr_pkg::OP_DIV: begin
				d_q <= prod;
				y_q <= prod;
			end
			rmdr_pkg::OP_GCD_SWAP: begin
				x_q <= y_q;
				y_q <= rem;
			end
			rmdr_pkg::OP_REDUCE_N: n_q <= quot;
			rmdr_pkg::OP_REDUCE_D: d_q <= quot;
			rmdr_pkg::OP_FINISH: begin
				if (d_q == 64'd0) begin
					res <= {32'd0, 31'd1, rmdr_pkg::ERR_ZDEN};
				end else if (n_q == 64'd0) begin
					res <= {32'd0, 31'd1, rmdr_pkg::ERR_OK};
				end else if (out_range) begin
					res <= {32'd0, 31'd1, rmdr_pkg::ERR_RANGE};
				end else begin
					res.res_num <= neg_q ? (32'd0 - n_q[31:0]) : n_q[31:0];
					res.res_den <= d_q[30:0];
					res.error   <= rmdr_pkg::ERR_OK;
				end
			end
			default: ;
		endcase
	end

	assign sts.div_done = div_done;
	assign sts.den_zero = (d_q == 64'd0);
	assign sts.num_zero = (n_q == 64'd0);
	assign sts.rem_zero = (y_q == 64'd0);

endmodule

/* hdl/rmdr_ctrl.sv */
// ---------------------------------------------------------------------------
// Rational reduce controller
// Sequences load, products, Euclid loop, reduction and result strobe.
// ---------------------------------------------------------------------------
module rmdr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rmdr_pkg::sts_t sts,
	output rmdr_pkg::cmd_t ctl,
	output logic           busy,
	output logic           valid
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_CHECK = 4'd3;
	localparam logic [3:0] S_GTEST = 4'd4;
	localparam logic [3:0] S_GWAIT = 4'd5;
	localparam logic [3:0] S_NWAIT = 4'd6;
	localparam logic [3:0] S_DWAIT = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       launch_q, launch_d;

	// Next state and datapath command.
	always_comb begin
		state_d       = state_q;
		launch_d      = 1'b0;
		ctl.op        = rmdr_pkg::OP_NONE;
		ctl.div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op  = rmdr_pkg::OP_LOAD;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				ctl.op  = rmdr_pkg::OP_MUL;
				state_d = S_DIV;
			end
			S_DIV: begin
				ctl.op  = rmdr_pkg::OP_DIV;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = (sts.den_zero || sts.num_zero) ? S_FIN : S_GTEST;
			end
			S_GTEST: begin
				if (sts.rem_zero) begin
					ctl.op        = rmdr_pkg::OP_REDUCE_N;
					ctl.div_start = 1'b1;
					state_d       = S_NWAIT;
				end else begin
					ctl.div_start = 1'b1;
					state_d       = S_GWAIT;
				end
			end
			S_GWAIT: begin
				if (sts.div_done) begin
					ctl.op  = rmdr_pkg::OP_GCD_SWAP;
					state_d = S_GTEST;
				end
			end
			S_NWAIT: begin
				if (sts.div_done) begin
					ctl.op        = rmdr_pkg::OP_REDUCE_N;
					launch_d      = 1'b1;
					state_d       = S_DWAIT;
				end else begin
					ctl.op = rmdr_pkg::OP_NONE;
				end
			end
			S_DWAIT: begin
				if (launch_q) begin
					ctl.op        = rmdr_pkg::OP_REDUCE_D;
					ctl.div_start = 1'b1;
				end else if (sts.div_done) begin
					ctl.op  = rmdr_pkg::OP_REDUCE_D;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				ctl.op  = rmdr_pkg::OP_FINISH;
				state_d = S_OUT;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign valid = (state_q == S_OUT);

endmodule

/* sim/tb_rational_mul_div_reduce.sv */
// ---------------------------------------------------------------------------
// Testbench for the rational multiply/divide reduce block
// Drives directed and random requests, types or predicts each reduced fraction
// and its error code, and compares every result against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_rational_mul_div_reduce;

	localparam int WIDTH     = 32;
	localparam int N_RANDOM  = 830;
	localparam int DRAIN_CYC = 200;

	typedef struct {
		rmdr_pkg::req_t rq;
		bit             typed;
		rmdr_pkg::res_t want;
	} vec_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	rmdr_pkg::req_t req;
	logic           busy;
	logic           valid;
	rmdr_pkg::res_t res;

	rmdr_pkg::res_t fraction_q[$];
	int             n_fail;
	vec_t           vecs[$];

	rational_mul_div_reduce #(.WIDTH(WIDTH)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.valid (valid),
		.res   (res)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung block.
	initial begin
		#400_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Reduced product or quotient of the two fractions, with error code.
	function automatic rmdr_pkg::res_t reduce_fraction(rmdr_pkg::req_t r);
		logic [63:0]    an, bn, ad, bd, n, d, x, y, t, lim;
		bit             neg;
		rmdr_pkg::res_t o;
		an  = {32'd0, r.a_num[31] ? (~r.a_num + 32'd1) : r.a_num};
		bn  = {32'd0, r.b_num[31] ? (~r.b_num + 32'd1) : r.b_num};
		ad  = {33'd0, r.a_den};
		bd  = {33'd0, r.b_den};
		neg = r.a_num[31] ^ r.b_num[31];
		lim = (64'd1 << (WIDTH - 1)) - 64'd1;
		o.res_num = '0;
		o.res_den = 31'd1;
		o.error   = rmdr_pkg::ERR_OK;
		if (r.cmd == rmdr_pkg::CMD_MUL) begin
			n = an * bn;
			d = ad * bd;
		end else begin
			n = an * bd;
			d = ad * bn;
		end
		if (d == 64'd0) begin
			o.error = rmdr_pkg::ERR_ZDEN;
		end else if (n != 64'd0) begin
			x = n;
			y = d;
			while (y != 64'd0) begin
				t = x % y;
				x = y;
				y = t;
			end
			n = n / x;
			d = d / x;
			if (d > lim || n > (neg ? lim + 64'd1 : lim)) begin
				o.error = rmdr_pkg::ERR_RANGE;
			end else begin
				o.res_num = neg ? (32'd0 - n[31:0]) : n[31:0];
				o.res_den = d[30:0];
			end
		end
		return o;
	endfunction

	function automatic rmdr_pkg::req_t mk(logic c, logic [31:0] an, logic [30:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		rmdr_pkg::req_t r;
		r.cmd   = c;
		r.a_num = an;
		r.a_den = ad;
		r.b_num = bn;
		r.b_den = bd;
		return r;
	endfunction

	function automatic void add_row(rmdr_pkg::req_t r, bit typed, rmdr_pkg::res_t want);
		vec_t v;
		v.rq    = r;
		v.typed = typed;
		v.want  = want;
		vecs.push_back(v);
	endfunction

	function automatic rmdr_pkg::res_t frac(logic [31:0] n, logic [30:0] d,
			logic [1:0] e);
		rmdr_pkg::res_t o;
		o.res_num = n;
		o.res_den = d;
		o.error   = e;
		return o;
	endfunction

	// Random operand: mostly small values that share factors, some full width.
	function automatic logic [31:0] rnd_num();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 5)
			return 32'd0;
		else if (k < 55)
			return $urandom_range(0, 1) ? $urandom_range(1, 5000) : -$urandom_range(1, 5000);
		else if (k < 65)
			return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		else
			return $urandom;
	endfunction

	function automatic logic [30:0] rnd_den();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 3)
			return 31'd0;
		else if (k < 55)
			return 31'($urandom_range(1, 5000));
		else if (k < 62)
			return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd1;
		else
			return 31'($urandom);
	endfunction

	// Idle cycles before a request: mostly none or short, a few long.
	function automatic int rnd_gap();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		else if (k < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	// Issue one request and hold it until the block takes it.
	task automatic send_request(rmdr_pkg::req_t r, rmdr_pkg::res_t want);
		int gap;
		gap = rnd_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		fraction_q.push_back(want);
	endtask

	// Result checker: each strobed result must match the oldest prediction.
	always @(posedge clk) begin
		rmdr_pkg::res_t w;
		if (arst_n && valid) begin
			if (fraction_q.size() == 0) begin
				$display("%0t: unexpected result num=%h den=%h err=%0d",
					$time, res.res_num, res.res_den, res.error);
				n_fail++;
			end else begin
				w = fraction_q.pop_front();
				if (res.res_num !== w.res_num || res.res_den !== w.res_den ||
						res.error !== w.error) begin
					$display({"%0t: mismatch expected num=%h den=%h err=%0d",
						" actual num=%h den=%h err=%0d"},
						$time, w.res_num, w.res_den, w.error,
						res.res_num, res.res_den, res.error);
					n_fail++;
				end
			end
		end
	end

	// Stimulus.
	initial begin
		rmdr_pkg::req_t r;
		int             wait_cyc;
		n_fail = 0;
		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: typed results for special cases, predictor for the rest.
		add_row(mk(rmdr_pkg::CMD_MUL, 32'd1, 31'd1, 32'd1, 31'd1), 1,
			frac(32'd1, 31'd1, rmdr_pkg::ERR_OK));
		add_row(mk(rmdr_pkg::CMD_DIV, 32'd5, 31'd3, 32'd0, 31'd7), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_ZDEN));
		add_row(mk(rmdr_pkg::CMD_MUL, 32'd5, 31'd0, 32'd2, 31'd7), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_ZDEN));
		add_row(mk(rmdr_pkg::CMD_MUL, 32'd5, 31'd3, 32'd2, 31'd0), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_ZDEN));
		add_row(mk(rmdr_pkg::CMD_DIV, 32'd0, 31'd3, 32'd0, 31'd7), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_ZDEN));
		add_row(mk(rmdr_pkg::CMD_MUL, 32'd0, 31'd9, 32'h8000_0000, 31'd7), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_OK));
		add_row(mk(rmdr_pkg::CMD_DIV, 32'd0, 31'h7fff_ffff, 32'd4, 31'd3), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_OK));
		add_row(mk(rmdr_pkg::CMD_MUL, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_RANGE));
		add_row(mk(rmdr_pkg::CMD_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1), 1,
			frac(32'h8000_0000, 31'd1, rmdr_pkg::ERR_OK));
		add_row(mk(rmdr_pkg::CMD_MUL, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_RANGE));
		add_row(mk(rmdr_pkg::CMD_MUL, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_ffff), 1,
			frac(32'd0, 31'd1, rmdr_pkg::ERR_RANGE));
		add_row(mk(rmdr_pkg::CMD_DIV, 32'h7fff_ffff, 31'h7fff_ffff,
			32'h8000_0000, 31'h7fff_ffff), 0, '0);
		add_row(mk(rmdr_pkg::CMD_DIV, 32'h8000_0000, 31'h7fff_ffff,
			32'h8000_0000, 31'h7fff_ffff), 0, '0);
		add_row(mk(rmdr_pkg::CMD_DIV, 32'd1, 31'd1, 32'h8000_0000, 31'd1), 0, '0);
		add_row(mk(rmdr_pkg::CMD_DIV, 32'hffff_ffff, 31'd1, 32'h8000_0000, 31'd1), 0, '0);
		add_row(mk(rmdr_pkg::CMD_MUL, 32'd6, 31'd35, 32'hffff_fff2, 31'd9), 0, '0);
		add_row(mk(rmdr_pkg::CMD_DIV, 32'hffff_fffa, 31'd35, 32'hffff_fff2, 31'd9), 0, '0);
		add_row(mk(rmdr_pkg::CMD_DIV, 32'd3, 31'd4, 32'd3, 31'd4), 0, '0);
		add_row(mk(rmdr_pkg::CMD_MUL, 32'h5555_5555, 31'h2aaa_aaaa,
			32'haaaa_aaaa, 31'h5555_5555), 0, '0);
		add_row(mk(rmdr_pkg::CMD_DIV, 32'd1, 31'h7fff_ffff, 32'hffff_ffff, 31'd1), 0, '0);

		foreach (vecs[i])
			send_request(vecs[i].rq,
				vecs[i].typed ? vecs[i].want : reduce_fraction(vecs[i].rq));

		// Random requests checked against the predictor.
		for (int i = 0; i < N_RANDOM; i++) begin
			r = mk(1'($urandom_range(0, 1)), rnd_num(), rnd_den(), rnd_num(), rnd_den());
			send_request(r, reduce_fraction(r));
		end
		start <= 1'b0;

		// Drain outstanding results, then allow trailing cycles.
		wait_cyc = 0;
		while (fraction_q.size() != 0 && wait_cyc < 100000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (DRAIN_CYC) @(posedge clk);
		if (n_fail == 0 && fraction_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (fraction_q.size() != 0)
				$display("%0t: %0d results never arrived", $time, fraction_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
